// ===== design/tplru_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tplru_pkg: shared types and codes of the two-partition LRU id table
// Item layouts, partition and cell command codes, default table depths.
// ----------------------------------------------------------------------------
package tplru_pkg;

   localparam int INTERIOR_DEPTH_DEF = 8;
   localparam int EXTERIOR_DEPTH_DEF = 16;

   // operation codes of a request item
   localparam logic [2:0] OP_LOOKUP     = 3'd0;
   localparam logic [2:0] OP_INSERT_INT = 3'd1;
   localparam logic [2:0] OP_INSERT_EXT = 3'd2;
   localparam logic [2:0] OP_PROMOTE    = 3'd3;
   localparam logic [2:0] OP_PURGE      = 3'd4;

   // partition commands
   localparam logic [1:0] PART_NONE    = 2'd0;
   localparam logic [1:0] PART_APPEND  = 2'd1;
   localparam logic [1:0] PART_PROMOTE = 2'd2;
   localparam logic [1:0] PART_PURGE   = 2'd3;

   // cell commands
   localparam logic [1:0] CELL_HOLD  = 2'd0;
   localparam logic [1:0] CELL_SHIFT = 2'd1;
   localparam logic [1:0] CELL_LOAD  = 2'd2;

   typedef struct packed {
      logic [2:0]  operation;
      logic [31:0] cell_id;
      logic [15:0] handle;
      logic [7:0]  world_tag;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic        is_interior;
      logic [15:0] found_handle;
      logic        evicted;
   } rsp_type;

   typedef struct packed {
      logic [31:0] id;
      logic [15:0] handle;
      logic [7:0]  world;
   } entry_type;

   typedef struct packed {
      logic [1:0] cmd;
      entry_type  key;   // match key and new entry for an append
   } part_ctrl_type;

   typedef struct packed {
      logic        id_hit;
      logic        world_hit;
      logic        full;
      logic [15:0] handle;
   } part_status_type;

endpackage
`default_nettype wire

// ===== design/tplru_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tplru_cell: one table slot
// Holds one entry, compares it with the key, and takes its newer neighbor's
// entry or a fresh entry on command.
// ----------------------------------------------------------------------------
module tplru_cell
   import tplru_pkg::*;
(
   input  wire logic       clock,
   input  wire logic [1:0] cell_cmd,
   input  wire entry_type  next_entry,
   input  wire entry_type  load_entry,
   input  wire entry_type  key,
   output entry_type       entry,
   output logic            id_match,
   output logic            world_match
);

   entry_type entry_ff, entry_in;

   always_comb begin
      case (cell_cmd)
         CELL_SHIFT: entry_in = next_entry;
         CELL_LOAD:  entry_in = load_entry;
         default:    entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry       = entry_ff;
   assign id_match    = (entry_ff.id == key.id);
   assign world_match = (entry_ff.world == key.world);

endmodule
`default_nettype wire

// ===== design/tplru_part.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tplru_part: one recency-ordered partition
// A chain of cells, slot 0 oldest, with the fill count and the first-match
// logic that turns a command into per-cell hold, shift or load.
// ----------------------------------------------------------------------------
module tplru_part
   import tplru_pkg::*;
#(
   parameter int DEPTH = INTERIOR_DEPTH_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire part_ctrl_type ctrl,
   output part_status_type    status
);

   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0] count_ff, count_in;
   entry_type     cell_q   [DEPTH];
   logic [1:0]    cell_cmd [DEPTH];
   entry_type     load_entry;
   entry_type     moved;
   logic [DEPTH-1:0] id_m, world_m, live, sel_m, first, after;
   logic          full, any_sel;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type next_entry;
      if (i == DEPTH - 1) begin : g_last
         assign next_entry = cell_q[i];
      end else begin : g_mid
         assign next_entry = cell_q[i + 1];
      end
      assign live[i] = (CW'(i) < count_ff);
      tplru_cell u_cell (
         .clock       (clock),
         .cell_cmd    (cell_cmd[i]),
         .next_entry  (next_entry),
         .load_entry  (load_entry),
         .key         (ctrl.key),
         .entry       (cell_q[i]),
         .id_match    (id_m[i]),
         .world_match (world_m[i])
      );
   end

   assign full = (count_ff == CW'(DEPTH));

   // oldest match wins; everything from it upward moves down on a removal
   always_comb begin
      logic seen;
      seen  = 1'b0;
      moved = '0;
      sel_m = (ctrl.cmd == PART_PURGE) ? (world_m & live) : (id_m & live);
      for (int i = 0; i < DEPTH; i++) begin
         first[i] = sel_m[i] & ~seen;
         seen     = seen | sel_m[i];
         after[i] = seen;
         if (first[i]) begin
            moved = moved | cell_q[i];
         end
      end
   end

   assign any_sel    = |sel_m;
   assign load_entry = (ctrl.cmd == PART_PROMOTE) ? moved : ctrl.key;

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_cmd[i] = CELL_HOLD;
         case (ctrl.cmd)
            PART_APPEND: begin
               if (full) begin
                  cell_cmd[i] = (i == DEPTH - 1) ? CELL_LOAD : CELL_SHIFT;
               end else if (CW'(i) == count_ff) begin
                  cell_cmd[i] = CELL_LOAD;
               end
            end
            PART_PROMOTE: begin
               if (any_sel) begin
                  if (CW'(i) == count_ff - CW'(1)) begin
                     cell_cmd[i] = CELL_LOAD;
                  end else if (after[i] && (CW'(i + 1) < count_ff)) begin
                     cell_cmd[i] = CELL_SHIFT;
                  end
               end
            end
            PART_PURGE: begin
               if (after[i] && (CW'(i + 1) < count_ff)) begin
                  cell_cmd[i] = CELL_SHIFT;
               end
            end
            default: cell_cmd[i] = CELL_HOLD;
         endcase
      end
   end

   always_comb begin
      count_in = count_ff;
      if ((ctrl.cmd == PART_APPEND) && !full) begin
         count_in = count_ff + CW'(1);
      end else if ((ctrl.cmd == PART_PURGE) && any_sel) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign status.id_hit    = |(id_m & live);
   assign status.world_hit = |(world_m & live);
   assign status.full      = full;
   assign status.handle    = moved.handle;

endmodule
`default_nettype wire

// ===== design/two_partition_lru_id_table_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_partition_lru_id_table_unit: two recency-ordered cell id tables
// Interior and exterior partitions, each a chain of cells ordered oldest to
// newest, with lookup, insert, promote and world purge.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  req      in   req_valid / req_ready  req_data (req_type)
//  rsp      out  rsp_valid / rsp_ready  rsp_data (rsp_type)
//
//  Lookup, insert and promote pass ST_IDLE, which captures the item, and
//  ST_EXEC, in which both cell chains compare in parallel and shift at most
//  once. A purge stays in ST_EXEC until no exterior entry of its world is
//  left: the chain drops the oldest matching entry per cycle.
//  One item is in work at a time; a new item is taken while the previous
//  result still waits in the output register.
//  Reset clears both fill counts; the cell contents need no reset.
// ----------------------------------------------------------------------------
module two_partition_lru_id_table_unit
   import tplru_pkg::*;
#(
   parameter int INTERIOR_DEPTH = INTERIOR_DEPTH_DEF,
   parameter int EXTERIOR_DEPTH = EXTERIOR_DEPTH_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic            state_ff, state_in;
   req_type         req_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;
   part_ctrl_type   int_ctrl, ext_ctrl;
   part_status_type int_st, ext_st;
   logic            out_free;
   logic            finish;
   entry_type       key;

   assign key.id     = req_ff.cell_id;
   assign key.handle = req_ff.handle;
   assign key.world  = req_ff.world_tag;

   // output register is free when empty or being drained this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   tplru_part #(.DEPTH(INTERIOR_DEPTH)) u_int (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (int_ctrl),
      .status (int_st)
   );

   tplru_part #(.DEPTH(EXTERIOR_DEPTH)) u_ext (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ext_ctrl),
      .status (ext_st)
   );

   // decode the held item into partition commands and a result
   always_comb begin
      int_ctrl.cmd = PART_NONE;
      int_ctrl.key = key;
      ext_ctrl.cmd = PART_NONE;
      ext_ctrl.key = key;
      rsp_data_in  = '0;
      finish       = 1'b0;
      if (state_ff == ST_EXEC) begin
         case (req_ff.operation)
            OP_LOOKUP, OP_PROMOTE: begin
               finish                   = out_free;
               rsp_data_in.hit          = int_st.id_hit | ext_st.id_hit;
               rsp_data_in.is_interior  = int_st.id_hit;
               if (int_st.id_hit) begin
                  rsp_data_in.found_handle = int_st.handle;
               end else if (ext_st.id_hit) begin
                  rsp_data_in.found_handle = ext_st.handle;
               end
               // move the hit to newest only in the partition that hit first
               if ((req_ff.operation == OP_PROMOTE) && out_free) begin
                  if (int_st.id_hit) begin
                     int_ctrl.cmd = PART_PROMOTE;
                  end else if (ext_st.id_hit) begin
                     ext_ctrl.cmd = PART_PROMOTE;
                  end
               end
            end
            OP_INSERT_INT: begin
               finish              = out_free;
               rsp_data_in.evicted = int_st.full;
               if (out_free) begin
                  int_ctrl.cmd = PART_APPEND;
               end
            end
            OP_INSERT_EXT: begin
               finish              = out_free;
               rsp_data_in.evicted = ext_st.full;
               if (out_free) begin
                  ext_ctrl.cmd = PART_APPEND;
               end
            end
            OP_PURGE: begin
               // drop one matching entry per cycle, finish when none is left
               if (ext_st.world_hit) begin
                  ext_ctrl.cmd = PART_PURGE;
               end else begin
                  finish = out_free;
               end
            end
            default: begin
               finish = out_free;
            end
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (finish) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the item and the result payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      if (finish) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== design/tplru_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tplru_checker: port-level checks of the id table unit
// Watches the result channel for stall behavior and consistent result items.
// ----------------------------------------------------------------------------
module tplru_checker
   import tplru_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed or dropped while stalled");

   a_interior_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_interior |-> rsp_data.hit)
      else $error("interior flag without a hit");

   a_evict_no_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.evicted |-> !rsp_data.hit && !rsp_data.is_interior)
      else $error("eviction reported together with a hit");

   a_miss_handle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.found_handle == 16'd0)
      else $error("nonzero handle on a miss");

endmodule

bind two_partition_lru_id_table_unit tplru_checker u_tplru_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for two_partition_lru_id_table_unit
// Sends directed and random lookup, insert, promote and purge items with
// random gaps on both channels. A table predictor in the bench computes each
// expected result, and every returned item is checked field by field.
// ----------------------------------------------------------------------------
module tb_top;
   import tplru_pkg::*;

   localparam int          INNER_DEPTH    = INTERIOR_DEPTH_DEF;
   localparam int          OUTER_DEPTH    = EXTERIOR_DEPTH_DEF;
   localparam int          WATCHDOG_LIMIT = 2000;
   // drain longer than the longest purge, which removes up to OUTER_DEPTH entries
   localparam int          DRAIN_CYCLES   = 40;
   localparam logic [2:0]  OP_UNUSED_LO   = 3'd5;
   localparam logic [2:0]  OP_UNUSED_HI   = 3'd7;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   two_partition_lru_id_table_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Table predictor: interior and exterior tables, slot 0 oldest
   // ------------------------------------------------------------------------
   logic [31:0] inner_ids     [INNER_DEPTH];
   logic [15:0] inner_handles [INNER_DEPTH];
   int          inner_fill = 0;
   logic [31:0] outer_ids     [OUTER_DEPTH];
   logic [15:0] outer_handles [OUTER_DEPTH];
   logic [7:0]  outer_worlds  [OUTER_DEPTH];
   int          outer_fill = 0;

   rsp_type     pending_results [$];
   int          fail_count   = 0;
   int          idle_cycles  = 0;
   int          hold_cycles  = 0;
   bit          steady_run   = 1'b0;

   logic [31:0] id_pool    [16];
   logic [7:0]  world_pool [4];

   // Close the gap at pos in the interior table and drop its count.
   function automatic void inner_remove(input int pos);
      for (int i = pos; i < inner_fill - 1; i++) begin
         inner_ids[i]     = inner_ids[i + 1];
         inner_handles[i] = inner_handles[i + 1];
      end
      inner_fill--;
   endfunction

   function automatic void outer_remove(input int pos);
      for (int i = pos; i < outer_fill - 1; i++) begin
         outer_ids[i]     = outer_ids[i + 1];
         outer_handles[i] = outer_handles[i + 1];
         outer_worlds[i]  = outer_worlds[i + 1];
      end
      outer_fill--;
   endfunction

   // Apply one item to the predicted tables and return its result.
   function automatic rsp_type table_update(input req_type item);
      rsp_type    res;
      int         pos;
      int         kept;
      logic [7:0] keep_world;
      res = '0;
      pos = -1;
      case (item.operation)
         OP_LOOKUP, OP_PROMOTE: begin
            // interior first, oldest match wins
            for (int i = 0; i < inner_fill; i++)
               if (pos < 0 && inner_ids[i] == item.cell_id) pos = i;
            if (pos >= 0) begin
               res.hit          = 1'b1;
               res.is_interior  = 1'b1;
               res.found_handle = inner_handles[pos];
               if (item.operation == OP_PROMOTE) begin
                  inner_remove(pos);
                  inner_ids[inner_fill]     = item.cell_id;
                  inner_handles[inner_fill] = res.found_handle;
                  inner_fill++;
               end
            end else begin
               for (int i = 0; i < outer_fill; i++)
                  if (pos < 0 && outer_ids[i] == item.cell_id) pos = i;
               if (pos >= 0) begin
                  res.hit          = 1'b1;
                  res.found_handle = outer_handles[pos];
                  keep_world       = outer_worlds[pos];
                  if (item.operation == OP_PROMOTE) begin
                     outer_remove(pos);
                     outer_ids[outer_fill]     = item.cell_id;
                     outer_handles[outer_fill] = res.found_handle;
                     outer_worlds[outer_fill]  = keep_world;
                     outer_fill++;
                  end
               end
            end
         end
         OP_INSERT_INT: begin
            if (inner_fill >= INNER_DEPTH) begin
               inner_remove(0);
               res.evicted = 1'b1;
            end
            inner_ids[inner_fill]     = item.cell_id;
            inner_handles[inner_fill] = item.handle;
            inner_fill++;
         end
         OP_INSERT_EXT: begin
            if (outer_fill >= OUTER_DEPTH) begin
               outer_remove(0);
               res.evicted = 1'b1;
            end
            outer_ids[outer_fill]     = item.cell_id;
            outer_handles[outer_fill] = item.handle;
            outer_worlds[outer_fill]  = item.world_tag;
            outer_fill++;
         end
         OP_PURGE: begin
            // compact the survivors, keeping their order
            kept = 0;
            for (int i = 0; i < outer_fill; i++) begin
               if (outer_worlds[i] != item.world_tag) begin
                  outer_ids[kept]     = outer_ids[i];
                  outer_handles[kept] = outer_handles[i];
                  outer_worlds[kept]  = outer_worlds[i];
                  kept++;
               end
            end
            outer_fill = kept;
         end
         default: ;
      endcase
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Gaps: mostly none or short, now and then long; none in a steady run
   // ------------------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      if (steady_run) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Stall the result channel at random; hold ready high in a steady run.
   always @(negedge clock) begin
      if (hold_cycles != 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready   <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!steady_run && $urandom_range(0, 3) == 0) hold_cycles <= pick_gap();
      end
   end

   // ------------------------------------------------------------------------
   // Result checker: compare each returned item with the oldest expectation
   // ------------------------------------------------------------------------
   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: mismatch in %s: expected %0h, actual %0h",
                  $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result with nothing expected: %p", $time, rsp_data);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("hit", 16'(want.hit), 16'(rsp_data.hit));
            check_field("is_interior", 16'(want.is_interior),
                        16'(rsp_data.is_interior));
            check_field("found_handle", want.found_handle, rsp_data.found_handle);
            check_field("evicted", 16'(want.evicted), 16'(rsp_data.evicted));
         end
      end
   end

   // Watchdog: end the run when no item moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item accepted for %0d cycles", $time, idle_cycles);
            $display("tb: failure");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sender: enter and leave at a falling edge; keep valid high across
   // back-to-back items so it is never dropped and raised in one step
   // ------------------------------------------------------------------------
   task automatic send_item(input req_type item);
      int      gap;
      rsp_type next_res;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      next_res        = table_update(item);
      pending_results = {pending_results, next_res};
      @(negedge clock);
   endtask

   function automatic req_type make_item(input logic [2:0] op, input logic [31:0] id,
                                         input logic [15:0] hd, input logic [7:0] wt);
      req_type item;
      item.operation = op;
      item.cell_id   = id;
      item.handle    = hd;
      item.world_tag = wt;
      return item;
   endfunction

   // Draw ids mostly from a small pool so that hits, duplicates and promotes
   // happen; the extremes of the id range are always in the pool.
   task automatic refill_pools();
      id_pool[0] = 32'h0000_0000;
      id_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < 16; i++) id_pool[i] = $urandom;
      world_pool[0] = 8'h00;
      world_pool[1] = 8'hFF;
      world_pool[2] = 8'($urandom_range(1, 254));
      world_pool[3] = 8'($urandom_range(1, 254));
   endtask

   function automatic req_type random_item(input int w_lookup, input int w_int,
                                           input int w_ext, input int w_promote,
                                           input int w_purge);
      req_type item;
      int      r;
      item.cell_id   = ($urandom_range(0, 99) < 85) ? id_pool[$urandom_range(0, 15)]
                                                    : $urandom;
      item.handle    = 16'($urandom_range(0, 65535));
      item.world_tag = ($urandom_range(0, 9) < 8) ? world_pool[$urandom_range(0, 3)]
                                                  : 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 3) begin
         item.operation = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      end else begin
         r = $urandom_range(0, w_lookup + w_int + w_ext + w_promote + w_purge - 1);
         if (r < w_lookup)                                  item.operation = OP_LOOKUP;
         else if (r < w_lookup + w_int)                     item.operation = OP_INSERT_INT;
         else if (r < w_lookup + w_int + w_ext)             item.operation = OP_INSERT_EXT;
         else if (r < w_lookup + w_int + w_ext + w_promote) item.operation = OP_PROMOTE;
         else                                               item.operation = OP_PURGE;
      end
      return item;
   endfunction

   task automatic issue_random(input int count, input int w_lookup, input int w_int,
                               input int w_ext, input int w_promote, input int w_purge);
      refill_pools();
      repeat (count) send_item(random_item(w_lookup, w_int, w_ext, w_promote, w_purge));
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Miss on empty tables, purge of nothing, unused codes leave no trace.
   task automatic test_empty_table();
      send_item(make_item(OP_LOOKUP, 32'h0, 16'h0, 8'h0));
      send_item(make_item(OP_PROMOTE, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF));
      send_item(make_item(OP_PURGE, 32'h0, 16'h0, 8'h0));
      send_item(make_item(OP_UNUSED_LO, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF));
      send_item(make_item(OP_UNUSED_HI, 32'hA5A5_5A5A, 16'h5AA5, 8'hA5));
   endtask

   // Fill the interior table and push one past full to evict the oldest.
   task automatic test_interior_eviction();
      send_item(make_item(OP_INSERT_INT, 32'h0, 16'h0, 8'h0));
      send_item(make_item(OP_INSERT_INT, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF));
      for (int i = 2; i <= INNER_DEPTH; i++)
         send_item(make_item(OP_INSERT_INT, 32'h100 + i,
                             16'($urandom_range(0, 65535)), 8'h0));
      send_item(make_item(OP_LOOKUP, 32'h0, 16'h0, 8'h0));
      send_item(make_item(OP_LOOKUP, 32'hFFFF_FFFF, 16'h0, 8'h0));
   endtask

   // Promote the oldest interior entry, then promote it again while newest.
   task automatic test_promote_order();
      send_item(make_item(OP_PROMOTE, 32'hFFFF_FFFF, 16'h0, 8'h0));
      send_item(make_item(OP_PROMOTE, 32'hFFFF_FFFF, 16'h0, 8'h0));
   endtask

   // Duplicates across and within partitions, exterior promote, world purge.
   task automatic test_exterior_and_purge();
      send_item(make_item(OP_INSERT_EXT, 32'hFFFF_FFFF, 16'h1111, 8'h00));
      send_item(make_item(OP_INSERT_EXT, 32'h0000_C0DE, 16'hFFFF, 8'hFF));
      send_item(make_item(OP_INSERT_EXT, 32'h0000_C0DE, 16'h0001, 8'h01));
      send_item(make_item(OP_LOOKUP, 32'hFFFF_FFFF, 16'h0, 8'h0));
      send_item(make_item(OP_LOOKUP, 32'h0000_C0DE, 16'h0, 8'h0));
      send_item(make_item(OP_PROMOTE, 32'h0000_C0DE, 16'h0, 8'h0));
      send_item(make_item(OP_LOOKUP, 32'h0000_C0DE, 16'h0, 8'h0));
      send_item(make_item(OP_PURGE, 32'h0, 16'h0, 8'hFF));
      send_item(make_item(OP_LOOKUP, 32'h0000_C0DE, 16'h0, 8'h0));
      send_item(make_item(OP_PROMOTE, 32'hFFFF_FFFF, 16'h0, 8'h0));
   endtask

   task automatic test_random_mixed();
      issue_random(250, 30, 15, 20, 25, 10);
   endtask

   // Lean on exterior inserts so the exterior table fills and evicts.
   task automatic test_exterior_fill();
      issue_random(200, 20, 10, 45, 20, 5);
   endtask

   // Hold both channels open: no sender gaps, no result stalls.
   task automatic test_back_to_back();
      steady_run = 1'b1;
      issue_random(100, 30, 20, 20, 20, 10);
      steady_run = 1'b0;
   endtask

   // Churn the exterior table with inserts and purges of a few worlds.
   task automatic test_purge_churn();
      issue_random(100, 15, 5, 40, 10, 30);
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_interior_eviction();
      test_promote_order();
      test_exterior_and_purge();
      test_random_mixed();
      test_exterior_fill();
      test_back_to_back();
      test_purge_churn();

      // drop valid, drain all results, then idle past the longest latency
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/tplru_pkg.sv
design/tplru_cell.sv
design/tplru_part.sv
design/two_partition_lru_id_table_unit.sv
design/tplru_checker.sv
test/tb_top.sv
